// ----- sv/phc_pkg.sv -----
// proximity hazard classifier: shared types, codes and constants
`default_nettype none

package phc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    REQ_STATUS = 2'd0,
    REQ_LASER  = 2'd1,
    REQ_POINT  = 2'd2,
    REQ_TICK   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    MODE_UNKNOWN = 2'd0,
    MODE_IDLE    = 2'd1,
    MODE_ROLLING = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    LVL_GREEN  = 2'd0,
    LVL_YELLOW = 2'd1,
    LVL_RED    = 2'd2
  } level_t;

  typedef enum logic [2:0] {
    REG_CIRCLE    = 3'd0,
    REG_Z_UPPER   = 3'd1,
    REG_Z_LOWER   = 3'd2,
    REG_HOLD      = 3'd3,
    REG_THRESHOLD = 3'd4
  } reg_idx_t;

  localparam logic [15:0]        CIRCLE_RST    = 16'd2000;
  localparam logic signed [15:0] Z_UPPER_RST   = 16'sd900;
  localparam logic signed [15:0] Z_LOWER_RST   = -16'sd200;
  localparam logic [15:0]        HOLD_RST      = 16'd30;
  localparam logic [7:0]         THRESHOLD_RST = 8'd3;

  localparam logic [1:0] MODE_CODE_RESERVED = 2'd3;

  typedef struct packed {
    logic [15:0]        circle_mm;
    logic signed [15:0] z_upper_mm;
    logic signed [15:0] z_lower_mm;
    logic [15:0]        hold_ticks;
    logic [7:0]         count_threshold;
  } cfg_t;

  // classified transaction handed from front to back
  typedef struct packed {
    req_t       req;
    logic [1:0] mode;
    logic       last;
    level_t     laser_lvl;
    level_t     point_lvl;
  } cmd_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

`default_nettype wire

// ----- sv/phc_if.sv -----
// proximity hazard classifier: input and result channel interfaces
`default_nettype none

interface phc_in_if import phc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [1:0]                    scanner_mode;
  logic [15:0]                   range_mm;
  logic signed [COORD_WIDTH-1:0] point_x_mm;
  logic signed [COORD_WIDTH-1:0] point_y_mm;
  logic signed [COORD_WIDTH-1:0] point_z_mm;
  logic                          last_of_frame;

  modport source (
    output valid, req_type, scanner_mode, range_mm, point_x_mm, point_y_mm, point_z_mm,
    output last_of_frame,
    input  ready
  );
  modport sink (
    input  valid, req_type, scanner_mode, range_mm, point_x_mm, point_y_mm, point_z_mm,
    input  last_of_frame,
    output ready
  );
endinterface

interface phc_out_if import phc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  hazard_level;
  logic [15:0] ticks_since_hazard;

  modport source (output valid, hazard_level, ticks_since_hazard, input ready);
  modport sink (input valid, hazard_level, ticks_since_hazard, output ready);
endinterface

`default_nettype wire

// ----- sv/phc_front.sv -----
// proximity hazard classifier: front end, grades samples and points against the circle
`default_nettype none

module phc_front import phc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  phc_in_if.sink in_ch,
  input  logic  q_full,
  output logic  q_push,
  output cmd_t  q_data
);

  localparam int SQW  = 2 * COORD_WIDTH;
  localparam int ZW   = (COORD_WIDTH > 16) ? COORD_WIDTH : 16;
  localparam int CMPW = (2 * COORD_WIDTH + 5 > 33) ? 2 * COORD_WIDTH + 5 : 33;

  logic                   in_acc;
  logic [COORD_WIDTH-1:0] ax;
  logic [COORD_WIDTH-1:0] ay;
  logic signed [ZW-1:0]   z_ext;
  logic signed [ZW-1:0]   zu_ext;
  logic signed [ZW-1:0]   zl_ext;
  logic [17:0]            r3;
  level_t                 laser_lvl;

  logic             s1_valid;
  req_t             s1_req;
  logic [1:0]       s1_mode;
  logic             s1_last;
  level_t           s1_laser;
  logic             s1_zpass;
  logic [SQW-1:0]   s1_sqx;
  logic [SQW-1:0]   s1_sqy;
  logic [31:0]      c2;

  logic [CMPW-1:0]  d2w;
  logic [CMPW-1:0]  d2x9;
  logic [CMPW-1:0]  c2w;
  level_t           pt_lvl;

  assign in_ch.ready = !s1_valid || !q_full;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign q_push      = s1_valid && !q_full;

  // planar magnitudes, the most negative code maps onto its unsigned value
  assign ax = in_ch.point_x_mm[COORD_WIDTH-1] ? (~in_ch.point_x_mm + 1'b1) : in_ch.point_x_mm;
  assign ay = in_ch.point_y_mm[COORD_WIDTH-1] ? (~in_ch.point_y_mm + 1'b1) : in_ch.point_y_mm;

  assign z_ext  = ZW'(in_ch.point_z_mm);
  assign zu_ext = ZW'(cfg.z_upper_mm);
  assign zl_ext = ZW'(cfg.z_lower_mm);

  assign r3 = ({2'b00, in_ch.range_mm} << 1) + {2'b00, in_ch.range_mm};

  always_comb begin
    if (in_ch.range_mm < cfg.circle_mm) begin
      laser_lvl = (r3 < {2'b00, cfg.circle_mm}) ? LVL_RED : LVL_YELLOW;
    end else begin
      laser_lvl = LVL_GREEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    c2 <= 32'(cfg.circle_mm) * 32'(cfg.circle_mm);
    if (in_acc) begin
      s1_req   <= req_t'(in_ch.req_type);
      s1_mode  <= in_ch.scanner_mode;
      s1_last  <= in_ch.last_of_frame;
      s1_laser <= laser_lvl;
      s1_zpass <= !(z_ext > zu_ext || z_ext < zl_ext);
      s1_sqx   <= SQW'(ax) * SQW'(ax);
      s1_sqy   <= SQW'(ay) * SQW'(ay);
    end
  end

  assign d2w  = CMPW'(s1_sqx) + CMPW'(s1_sqy);
  assign d2x9 = (d2w << 3) + d2w;
  assign c2w  = CMPW'(c2);

  always_comb begin
    if (!s1_zpass || !(d2w < c2w)) begin
      pt_lvl = LVL_GREEN;
    end else if (d2x9 < c2w) begin
      pt_lvl = LVL_RED;
    end else begin
      pt_lvl = LVL_YELLOW;
    end
  end

  always_comb begin
    q_data.req       = s1_req;
    q_data.mode      = s1_mode;
    q_data.last      = s1_last;
    q_data.laser_lvl = s1_laser;
    q_data.point_lvl = pt_lvl;
  end

endmodule

`default_nettype wire

// ----- sv/phc_queue.sv -----
// proximity hazard classifier: short transaction queue between front and back
`default_nettype none

module phc_queue import phc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [NW-1:0] FULL_CNT = NW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count != '0 && count != FULL_CNT |-> wr_ptr != rd_ptr)
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- sv/phc_back.sv -----
// proximity hazard classifier: back end, hazard state, tick counter and result register
`default_nettype none

module phc_back import phc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  q_empty,
  input  cmd_t  q_data,
  output logic  q_pop,
  phc_out_if.source out_ch
);

  mode_t       mode_reg;
  level_t      level_reg;
  logic [15:0] tick_count;
  logic        sample_parity;
  logic [15:0] red_hits;
  logic [15:0] yellow_hits;
  level_t      cloud_level;

  mode_t       mode_reg_next;
  level_t      level_reg_next;
  logic [15:0] tick_count_next;
  logic        sample_parity_next;
  logic [15:0] red_hits_next;
  logic [15:0] yellow_hits_next;
  level_t      cloud_level_next;
  level_t      cloud_max;

  logic        out_valid;
  level_t      out_level;
  logic [15:0] out_ticks;
  logic        out_load;

  assign q_pop    = !q_empty && (q_data.req != REQ_TICK || !out_valid || out_ch.ready);
  assign out_load = q_pop && q_data.req == REQ_TICK;

  assign cloud_max = (q_data.point_lvl > cloud_level) ? q_data.point_lvl : cloud_level;

  always_comb begin
    mode_reg_next      = mode_reg;
    level_reg_next     = level_reg;
    tick_count_next    = tick_count;
    sample_parity_next = sample_parity;
    red_hits_next      = red_hits;
    yellow_hits_next   = yellow_hits;
    cloud_level_next   = cloud_level;
    if (q_pop) begin
      unique case (q_data.req)
        REQ_STATUS: begin
          mode_reg_next      = (q_data.mode == MODE_CODE_RESERVED) ? MODE_UNKNOWN
                                                                   : mode_t'(q_data.mode);
          red_hits_next      = '0;
          yellow_hits_next   = '0;
          sample_parity_next = 1'b0;
          cloud_level_next   = LVL_GREEN;
        end
        REQ_LASER: begin
          if (mode_reg == MODE_IDLE) begin
            if (!sample_parity && q_data.laser_lvl == LVL_RED) begin
              red_hits_next = sat_inc16(red_hits);
            end
            if (!sample_parity && q_data.laser_lvl == LVL_YELLOW) begin
              yellow_hits_next = sat_inc16(yellow_hits);
            end
            sample_parity_next = !sample_parity;
            if (q_data.last) begin
              // yellow first, red overrides
              if (yellow_hits_next > 16'(cfg.count_threshold)) begin
                level_reg_next  = LVL_YELLOW;
                tick_count_next = '0;
              end
              if (red_hits_next > 16'(cfg.count_threshold)) begin
                level_reg_next  = LVL_RED;
                tick_count_next = '0;
              end
              red_hits_next      = '0;
              yellow_hits_next   = '0;
              sample_parity_next = 1'b0;
            end
          end
        end
        REQ_POINT: begin
          if (mode_reg == MODE_ROLLING) begin
            if (q_data.point_lvl != LVL_GREEN) begin
              cloud_level_next = cloud_max;
              level_reg_next   = cloud_max;
              tick_count_next  = '0;
            end
            if (q_data.last) begin
              cloud_level_next = LVL_GREEN;
            end
          end
        end
        REQ_TICK: begin
          tick_count_next = sat_inc16(tick_count);
          if (tick_count_next > cfg.hold_ticks) begin
            level_reg_next = LVL_GREEN;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= MODE_UNKNOWN;
      level_reg     <= LVL_GREEN;
      tick_count    <= '0;
      sample_parity <= 1'b0;
      red_hits      <= '0;
      yellow_hits   <= '0;
      cloud_level   <= LVL_GREEN;
      out_valid     <= 1'b0;
    end else begin
      mode_reg      <= mode_reg_next;
      level_reg     <= level_reg_next;
      tick_count    <= tick_count_next;
      sample_parity <= sample_parity_next;
      red_hits      <= red_hits_next;
      yellow_hits   <= yellow_hits_next;
      cloud_level   <= cloud_level_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_level <= level_reg_next;
      out_ticks <= tick_count_next;
    end
  end

  assign out_ch.valid              = out_valid;
  assign out_ch.hazard_level       = out_level;
  assign out_ch.ticks_since_hazard = out_ticks;

  a_tick_loads: assert property (@(posedge clk) disable iff (rst) out_load |=> out_valid)
    else $error("tick popped without a result");
  a_ticks_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_ticks != '0)
    else $error("reported tick count is zero");
  a_hold_green: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ticks > cfg.hold_ticks |-> out_level == LVL_GREEN)
    else $error("level not green after hold time");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |-> !out_load)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- sv/proximity_hazard_classifier_core.sv -----
// proximity hazard classifier: top level with register port, front, queue and back
//
//  channel  dir  kind        payload
//  in_ch    in   valid/ready req_type, scanner_mode, range_mm, point_{x,y,z}_mm, last_of_frame
//  out_ch   out  valid/ready hazard_level, ticks_since_hazard (one per tick)
//  apb      in   psel/penable circle, z window, hold, threshold at 4*index
//
//  one transaction per cycle unless stalled; a tick passes input reg, queue, result register
//  front: input register with planar squares, then distance compare into the queue
//  back: one queued transaction per cycle, a tick waits only while a result is unread
//  synchronous reset restores register defaults, green level and unknown mode
//  a stalled output holds a tick at the queue head and all behind it; a full queue stalls input
`default_nettype none

module proximity_hazard_classifier_core import phc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  phc_in_if.sink      in_ch,
  phc_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     wr_en;
  logic     q_full;
  logic     q_push;
  cmd_t     q_wdata;
  logic     q_pop;
  cmd_t     q_rdata;
  logic     q_empty;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.circle_mm       <= CIRCLE_RST;
      cfg.z_upper_mm      <= Z_UPPER_RST;
      cfg.z_lower_mm      <= Z_LOWER_RST;
      cfg.hold_ticks      <= HOLD_RST;
      cfg.count_threshold <= THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_CIRCLE:    cfg.circle_mm       <= pwdata[15:0];
        REG_Z_UPPER:   cfg.z_upper_mm      <= pwdata[15:0];
        REG_Z_LOWER:   cfg.z_lower_mm      <= pwdata[15:0];
        REG_HOLD:      cfg.hold_ticks      <= pwdata[15:0];
        REG_THRESHOLD: cfg.count_threshold <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CIRCLE:    prdata = {16'd0, cfg.circle_mm};
      REG_Z_UPPER:   prdata = 32'(cfg.z_upper_mm);
      REG_Z_LOWER:   prdata = 32'(cfg.z_lower_mm);
      REG_HOLD:      prdata = {16'd0, cfg.hold_ticks};
      REG_THRESHOLD: prdata = {24'd0, cfg.count_threshold};
      default:       prdata = '0;
    endcase
  end

  phc_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  phc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  phc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
